// ===== rtl/dag_list_scheduler_core_macros.svh =====
// Assertion macros for the list scheduler core.
`ifndef DAG_LIST_SCHEDULER_CORE_MACROS_SVH
`define DAG_LIST_SCHEDULER_CORE_MACROS_SVH
`define DLS_ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define DLS_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// ===== rtl/dls_pkg.sv =====
// Shared types and constants of the list scheduler core.
`default_nettype none
package dls_pkg;
  localparam logic [1:0] KIND_NODE = 2'd0;
  localparam logic [1:0] KIND_DEV = 2'd1;
  localparam logic [1:0] KIND_SUM = 2'd2;
  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_LEN = 3'd1;
  localparam logic [2:0] ERR_DUR = 3'd2;
  localparam logic [2:0] ERR_DEV = 3'd3;
  localparam logic [2:0] ERR_DEP = 3'd4;
  localparam logic [2:0] ERR_RUN = 3'd5;

  typedef struct packed {
    logic load;
    logic clear;
    logic val_step;
    logic val_start;
    logic tick_step;
    logic out_start;
    logic out_step;
  } cmd_t;

  typedef struct packed {
    logic last_load;
    logic val_done;
    logic [2:0] val_err;
    logic len_err;
    logic run_done;
    logic out_last;
    logic out_valid;
  } status_t;
endpackage
`default_nettype wire

// ===== rtl/dag_list_scheduler_core.sv =====
// Top level of the greedy list scheduler core.
// Usage: task records enter on the request channel in_valid/in_stall, one
// per cycle, with last_node marking the final record of a graph.
// After the final record the channel stalls while the core validates the
// graph, one node per cycle plus a closing check, and then, if no error was
// found, runs the schedule at one tick per cycle plus a final check; too
// many records skip both phases.
// Results leave on out_valid/out_stall, one per cycle when not stalled:
// per-node records, per-device records and a closing summary, or the
// summary alone when an error is found.
// A stall on the result channel holds the current record and pauses the
// output sequence; nothing is lost.
// After the summary is taken the core clears itself in its done state and
// then takes records again.
// Reset is synchronous and returns the core to the loading phase with an
// empty graph.
`default_nettype none
module dag_list_scheduler_core #(
  parameter int MAX_NODES = 32,
  parameter int DEVICES = 4,
  parameter int TICK_LIMIT = 4194304
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire [15:0]  duration,
  input  wire [7:0]   device_mask,
  input  wire [31:0]  dep_mask,
  input  wire         last_node,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  kind,
  output logic [4:0]  item_index,
  output logic [21:0] start_tick,
  output logic [22:0] finish_tick,
  output logic [1:0]  placed_device,
  output logic [4:0]  issue_order,
  output logic [22:0] tick_count,
  output logic [21:0] serial_total,
  output logic [22:0] stall_count,
  output logic [22:0] wait_count,
  output logic [2:0]  max_concurrency,
  output logic [2:0]  error
);
  import dls_pkg::*;
  `include "dag_list_scheduler_core_macros.svh"
  cmd_t cmd;
  status_t status;

  dls_ctrl u_ctrl (.clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .status(status), .cmd(cmd));

  dls_datapath #(.MAX_NODES(MAX_NODES), .DEVICES(DEVICES), .TICK_LIMIT(TICK_LIMIT))
  u_dp (.clk(clk), .rst(rst), .cmd(cmd), .status(status), .duration(duration),
    .device_mask(device_mask), .dep_mask(dep_mask), .last_node(last_node),
    .out_stall(out_stall), .kind(kind), .item_index(item_index),
    .start_tick(start_tick), .finish_tick(finish_tick),
    .placed_device(placed_device), .issue_order(issue_order),
    .tick_count(tick_count), .serial_total(serial_total),
    .stall_count(stall_count), .wait_count(wait_count),
    .max_concurrency(max_concurrency), .error(error));

  assign out_valid = status.out_valid;

  `DLS_ASSERT_IMPL(a_no_in_while_out, clk, rst, out_valid, in_stall)
  `DLS_ASSERT_IMPL(a_err_only_sum, clk, rst, out_valid && error != ERR_NONE, kind == KIND_SUM)
  `DLS_ASSERT_NEXT(a_sum_ends, clk, rst, out_valid && !out_stall && kind == KIND_SUM, !out_valid)
endmodule
`default_nettype wire

// ===== rtl/dls_datapath.sv =====
// Datapath: node stores, validation walk, tick engine and result sequencing.
`default_nettype none
module dls_datapath #(
  parameter int MAX_NODES = 32,
  parameter int DEVICES = 4,
  parameter int TICK_LIMIT = 4194304
) (
  input  wire               clk,
  input  wire               rst,
  input  wire dls_pkg::cmd_t cmd,
  output dls_pkg::status_t  status,
  input  wire [15:0]        duration,
  input  wire [7:0]         device_mask,
  input  wire [31:0]        dep_mask,
  input  wire               last_node,
  input  wire               out_stall,
  output logic [1:0]        kind,
  output logic [4:0]        item_index,
  output logic [21:0]       start_tick,
  output logic [22:0]       finish_tick,
  output logic [1:0]        placed_device,
  output logic [4:0]        issue_order,
  output logic [22:0]       tick_count,
  output logic [21:0]       serial_total,
  output logic [22:0]       stall_count,
  output logic [22:0]       wait_count,
  output logic [2:0]        max_concurrency,
  output logic [2:0]        error
);
  import dls_pkg::*;
  localparam int NW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int DW = (DEVICES > 1) ? $clog2(DEVICES) : 1;
  localparam int OW = $clog2(MAX_NODES + DEVICES + 1);
  localparam logic [7:0] DEVALL = 8'((1 << DEVICES) - 1);
  localparam logic [2:0] RUN_BUSY = 3'd0;
  localparam logic [2:0] RUN_FIN = 3'd1;
  localparam logic [2:0] RUN_STOP = 3'd2;

  logic [15:0] mem_dur [MAX_NODES];
  logic [7:0]  mem_dev [MAX_NODES];
  logic [31:0] mem_dep [MAX_NODES];
  logic [21:0] mem_st  [MAX_NODES];
  logic [22:0] mem_fi  [MAX_NODES];
  logic [1:0]  mem_pl  [MAX_NODES];
  logic [4:0]  mem_or  [MAX_NODES];

  logic [CW-1:0] node_count;
  logic len_flag;
  logic [MAX_NODES-1:0] done_bits, issued_bits;
  logic [DEVICES-1:0] slot_busy;
  logic [15:0] slot_rem [DEVICES];
  logic [NW-1:0] slot_node [DEVICES];
  logic [22:0] busy_ticks [DEVICES];
  logic [22:0] tick;
  logic [CW-1:0] retired;
  logic [5:0] seq;
  logic [21:0] serial_sum;
  logic [22:0] stall_sum, depwait_sum;
  logic [2:0] peak;
  logic [CW-1:0] vidx;
  logic bdur, bdev, bdep;
  logic [OW-1:0] oidx;
  logic ovalid;
  logic [2:0] run_code;

  // Validation walk, one node per cycle.
  logic [NW-1:0] vi;
  logic [63:0] range_mask;
  assign vi = vidx[NW-1:0];
  assign range_mask = ~((64'd1 << node_count) - 64'd1);

  // Tick evaluation.
  logic [DEVICES-1:0] freem;
  logic [MAX_NODES-1:0] ready;
  logic [MAX_NODES-1:0] place;
  logic sel_ok;
  logic [NW-1:0] sel;
  logic [DW-1:0] su;
  logic [DEVICES-1:0] occ;
  logic [3:0] conc;
  logic [7:0] selfree;
  logic [3:0] nret;
  always_comb begin
    freem = ~slot_busy;
    for (int i = 0; i < MAX_NODES; i++) begin
      ready[i] = (i < node_count) && !issued_bits[i] &&
                 ((mem_dep[i] & ~32'(done_bits)) == 32'd0);
      place[i] = ready[i] && ((mem_dev[i][DEVICES-1:0] & freem) != '0);
    end
    sel_ok = |place;
    sel = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) if (place[i]) sel = NW'(i);
    selfree = 8'(mem_dev[sel][DEVICES-1:0] & freem);
    su = '0;
    for (int u = DEVICES - 1; u >= 0; u--) if (selfree[u]) su = DW'(u);
    occ = slot_busy;
    if (sel_ok) occ[su] = 1'b1;
    conc = 4'($countones(occ));
    nret = '0;
    for (int u = 0; u < DEVICES; u++)
      if (slot_busy[u] && slot_rem[u] == 16'd0) nret = nret + 4'd1;
  end

  assign run_code = (retired == node_count) ? RUN_FIN :
                    (tick >= 23'(TICK_LIMIT)) ? RUN_STOP :
                    (!sel_ok && (slot_busy == '0)) ? RUN_STOP : RUN_BUSY;

  assign status.last_load = cmd.load & last_node;
  assign status.len_err = len_flag;
  assign status.val_done = (vidx == node_count);
  assign status.val_err = bdur ? ERR_DUR : bdev ? ERR_DEV : bdep ? ERR_DEP : ERR_NONE;
  assign status.run_done = run_code != RUN_BUSY;
  assign status.out_valid = ovalid;
  assign status.out_last = ovalid && !out_stall && kind == KIND_SUM;

  always_ff @(posedge clk) begin
    if (cmd.load && node_count < CW'(MAX_NODES)) begin
      mem_dur[node_count[NW-1:0]] <= duration;
      mem_dev[node_count[NW-1:0]] <= device_mask;
      mem_dep[node_count[NW-1:0]] <= dep_mask;
    end
    if (cmd.tick_step && run_code == RUN_BUSY) begin
      for (int u = 0; u < DEVICES; u++)
        if (slot_busy[u] && slot_rem[u] == 16'd0) mem_fi[slot_node[u]] <= tick + 23'd1;
      if (sel_ok) begin
        mem_st[sel] <= tick[21:0];
        mem_pl[sel] <= 2'(su);
        mem_or[sel] <= seq[4:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      node_count <= '0; len_flag <= 1'b0; done_bits <= '0; issued_bits <= '0;
      slot_busy <= '0; tick <= '0; retired <= '0; seq <= '0; serial_sum <= '0;
      stall_sum <= '0; depwait_sum <= '0; peak <= '0; vidx <= '0;
      bdur <= 1'b0; bdev <= 1'b0; bdep <= 1'b0;
      for (int u = 0; u < DEVICES; u++) begin
        slot_rem[u] <= '0; slot_node[u] <= '0; busy_ticks[u] <= '0;
      end
    end else begin
      if (cmd.load) begin
        if (node_count < CW'(MAX_NODES)) node_count <= node_count + CW'(1);
        else len_flag <= 1'b1;
      end
      if (cmd.val_start) vidx <= '0;
      if (cmd.val_step && vidx != node_count) begin
        if (mem_dur[vi] == 16'd0) bdur <= 1'b1;
        if (mem_dev[vi] == 8'd0 || (mem_dev[vi] & ~DEVALL) != 8'd0) bdev <= 1'b1;
        if (mem_dep[vi][vi] || ((64'(mem_dep[vi]) & range_mask) != 64'd0)) bdep <= 1'b1;
        serial_sum <= serial_sum + 22'(mem_dur[vi]) + 22'd1;
        vidx <= vidx + CW'(1);
      end
      if (cmd.tick_step && run_code == RUN_BUSY) begin
        for (int u = 0; u < DEVICES; u++) begin
          if (occ[u]) busy_ticks[u] <= busy_ticks[u] + 23'd1;
          if (slot_busy[u]) begin
            if (slot_rem[u] == 16'd0) begin
              slot_busy[u] <= 1'b0;
              done_bits[slot_node[u]] <= 1'b1;
            end else slot_rem[u] <= slot_rem[u] - 16'd1;
          end
        end
        retired <= retired + CW'(nret);
        if (conc > 4'(peak)) peak <= (conc > 4'd7) ? 3'd7 : conc[2:0];
        if (!sel_ok) begin
          if (|ready) stall_sum <= stall_sum + 23'd1;
          else depwait_sum <= depwait_sum + 23'd1;
        end else begin
          slot_busy[su] <= 1'b1;
          slot_rem[su] <= mem_dur[sel] - 16'd1;
          slot_node[su] <= sel;
          issued_bits[sel] <= 1'b1;
          seq <= seq + 6'd1;
        end
        tick <= tick + 23'd1;
      end
    end
  end

  // Result sequencing with a held output register.
  logic [2:0] ecode;
  logic [OW-1:0] nidx;
  logic [NW-1:0] rn;
  logic [DW-1:0] rd;
  logic [2:0] err_hold;
  logic [2:0] sum_err;
  assign ecode = len_flag ? ERR_LEN : (status.val_err != ERR_NONE) ? status.val_err :
                 run_code == RUN_STOP ? ERR_RUN : ERR_NONE;
  assign nidx = cmd.out_start ? ((ecode != ERR_NONE) ? OW'(node_count) + OW'(DEVICES) : '0)
                              : oidx + OW'(1);
  assign rn = nidx[NW-1:0];
  assign rd = DW'(nidx - OW'(node_count));
  assign sum_err = cmd.out_start ? ecode : err_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0; oidx <= '0; err_hold <= ERR_NONE;
    end else if (cmd.out_start || (cmd.out_step && ovalid && !out_stall)) begin
      if (cmd.out_start) err_hold <= ecode;
      if (!cmd.out_start && kind == KIND_SUM) ovalid <= 1'b0;
      else begin
        ovalid <= 1'b1; oidx <= nidx;
        if (nidx < OW'(node_count)) begin
          kind <= KIND_NODE; item_index <= 5'(rn);
          start_tick <= mem_st[rn]; finish_tick <= mem_fi[rn];
          placed_device <= mem_pl[rn]; issue_order <= mem_or[rn];
          tick_count <= '0; serial_total <= '0; stall_count <= '0;
          wait_count <= '0; max_concurrency <= '0; error <= ERR_NONE;
        end else if (nidx < OW'(node_count) + OW'(DEVICES)) begin
          kind <= KIND_DEV; item_index <= 5'(rd);
          start_tick <= '0; finish_tick <= '0; placed_device <= '0; issue_order <= '0;
          tick_count <= busy_ticks[rd]; serial_total <= '0; stall_count <= '0;
          wait_count <= '0; max_concurrency <= '0; error <= ERR_NONE;
        end else begin
          kind <= KIND_SUM; item_index <= '0;
          start_tick <= '0; finish_tick <= '0; placed_device <= '0; issue_order <= '0;
          error <= sum_err;
          if (sum_err != ERR_LEN) begin
            serial_total <= serial_sum; stall_count <= stall_sum;
            wait_count <= depwait_sum; max_concurrency <= peak;
            tick_count <= (sum_err == ERR_NONE) ? tick : 23'd0;
          end else begin
            serial_total <= '0; stall_count <= '0;
            wait_count <= '0; max_concurrency <= '0;
            tick_count <= '0;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/dls_ctrl.sv =====
// Controller: load, validate, run, emit and clear phases.
`default_nettype none
module dls_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire dls_pkg::status_t status,
  output dls_pkg::cmd_t     cmd
);
  import dls_pkg::*;
  typedef enum logic [4:0] {
    S_LOAD = 5'b00001, S_VAL = 5'b00010, S_RUN = 5'b00100,
    S_EMIT = 5'b01000, S_DONE = 5'b10000
  } state_t;
  state_t state, state_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    in_stall = (state != S_LOAD);
    case (state)
      S_LOAD: begin
        cmd.load = in_valid;
        cmd.val_start = 1'b1;
        if (in_valid && status.last_load) state_next = S_VAL;
      end
      S_VAL: begin
        cmd.val_step = 1'b1;
        if (status.len_err) begin
          cmd.out_start = 1'b1; state_next = S_EMIT;
        end else if (status.val_done) begin
          if (status.val_err != ERR_NONE) begin
            cmd.out_start = 1'b1; state_next = S_EMIT;
          end else state_next = S_RUN;
        end
      end
      S_RUN: begin
        cmd.tick_step = 1'b1;
        if (status.run_done) begin
          cmd.out_start = 1'b1; state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.out_step = 1'b1;
        if (status.out_last) state_next = S_DONE;
      end
      S_DONE: begin
        cmd.clear = 1'b1; state_next = S_LOAD;
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_LOAD;
    else state <= state_next;
  end
endmodule
`default_nettype wire
